// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the friction compensation checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfc_pkg.sv =====
// ---------------------------------------------------------------------------
// sfc_pkg
// Types, constants and elaboration-time helpers for the friction pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

    // Field widths.
    localparam int SPEED_W    = 24;
    localparam int TORQUE_W   = 32;
    localparam int GAIN_W     = 20;
    localparam int DB_W       = 23;
    localparam int X_W        = 29;   // |v| * inverse speed, Q.24, clamped at 16.0
    localparam int E_W        = 16;   // exponential, Q0.16
    localparam int VIS_W      = 28;   // rounded viscous or damping magnitude, Q.8
    localparam int STRI_W     = 21;   // rounded Stribeck magnitude, Q.8
    localparam int FRIC_W     = 30;   // unsaturated friction, signed Q.8
    localparam int CMD_W      = 35;   // unsaturated command, signed Q.8

    // Port widths.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_TUSER_W = 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 23;

    // Pipeline shape.
    localparam int PIPE_DEPTH         = 9;
    localparam int EXP_TABLE_BITS_DEF = 8;

    // Deadband direction codes.
    typedef logic [1:0] t_dir;
    localparam t_dir DIR_NONE = 2'b00;
    localparam t_dir DIR_FWD  = 2'b01;
    localparam t_dir DIR_BWD  = 2'b11;

    // Register indexes.
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_COULOMB   = 3'd0;
    localparam t_cfg_idx CFG_VISCOUS   = 3'd1;
    localparam t_cfg_idx CFG_BREAKAWAY = 3'd2;
    localparam t_cfg_idx CFG_INV_SPEED = 3'd3;
    localparam t_cfg_idx CFG_DEADBAND  = 3'd4;
    localparam t_cfg_idx CFG_DAMPING   = 3'd5;

    typedef struct packed {
        logic [GAIN_W-1:0] coulomb;
        logic [GAIN_W-1:0] viscous;
        logic [GAIN_W-1:0] breakaway;
        logic [GAIN_W-1:0] inv_speed;
        logic [DB_W-1:0]   deadband;
        logic [GAIN_W-1:0] damping;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        coulomb:   20'd8960,
        viscous:   20'd12800,
        breakaway: 20'd11008,
        inv_speed: 20'd2560,
        deadband:  23'd131,
        damping:   20'd256
    };

    // Per-item values that ride alongside the exponential pipeline.
    typedef struct packed {
        logic                       neg;
        t_dir                       dir;
        logic signed [TORQUE_W-1:0] dyn;
        logic [VIS_W-1:0]           vis_mag;
        logic [VIS_W-1:0]           damp_mag;
        logic [GAIN_W-1:0]          stri_mag;
        logic                       stri_neg;
    } t_side;

    typedef struct packed {
        logic                       clip;
        logic signed [TORQUE_W-1:0] val;
    } t_sat;

    localparam logic signed [CMD_W-1:0] I32_MAX_EXT = 35'sh0_7FFF_FFFF;
    localparam logic signed [CMD_W-1:0] I32_MIN_EXT = 35'sh7_8000_0000;

    // Clip a wide signed value to 32 bits and flag the clip.
    function automatic t_sat sat32(input logic signed [CMD_W-1:0] a);
        t_sat res;
        res.clip = 1'b1;
        if (a > I32_MAX_EXT) begin
            res.val = 32'sh7FFF_FFFF;
        end else if (a < I32_MIN_EXT) begin
            res.val = 32'sh8000_0000;
        end else begin
            res.clip = 1'b0;
            res.val  = a[TORQUE_W-1:0];
        end
        return res;
    endfunction

    // round(2^24 * exp(-num / 2^shft)), used only to build constant tables.
    // exp(-y) = (exp(-y / 2^20))^(2^20), the inner term by a second-order
    // series, then twenty squarings in Q.62.
    function automatic logic [24:0] exp_neg_q24(input int unsigned num,
                                                input int unsigned shft);
        logic [127:0] z;
        logic [127:0] v;
        logic [127:0] one;
        int           i;
        one = 128'd1 << 62;
        z   = ((128'(num) << 62) >> shft) >> 20;
        v   = one - z + ((z * z) >> 63);
        for (i = 0; i < 20; i++) begin
            v = (v * v) >> 62;
        end
        return 25'((v + (128'd1 << 37)) >> 38);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stribeck_friction_compensation.sv =====
// ---------------------------------------------------------------------------
// stribeck_friction_compensation
// Per-joint Stribeck friction compensation with damping, nine-stage pipeline.
// ---------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s         in         tdata: joint_speed [23:0], dynamics_torque [55:24]
//  m         out        tdata: friction_torque [31:0], command_torque [63:32],
//                              motion_direction [65:64]; tuser: saturated [0]
//  cfg       in         write enable, register index, data (no read-back)
//
//  One item per cycle sustained while the output accepts; each item passes
//  through the front, exponential and back stages to the output register.
//  Reset clears every stage valid bit and loads the default register values.
//  A stall on the output lets bubbles close up; stages holding an item
//  freeze, and input is refused only once every stage is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stribeck_friction_compensation #(
    parameter int EXP_TABLE_BITS = sfc_pkg::EXP_TABLE_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // joint_speed [23:0], dynamics_torque [55:24]
    input  wire  [sfc_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    // friction_torque [31:0], command_torque [63:32], motion_direction [65:64]
    output logic [sfc_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // saturated [0]
    output logic [sfc_pkg::OUT_TUSER_W-1:0]     o_m_tuser,
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    input  wire                                 i_cfg_we,
    input  wire  [sfc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [sfc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int D = sfc_pkg::PIPE_DEPTH;

    sfc_pkg::t_cfg                       r_cfg;
    logic [D:1]                          r_vld;
    logic [D:1]                          w_rdy;

    logic [sfc_pkg::X_W-1:0]             w_x;
    sfc_pkg::t_side                      w_side;
    sfc_pkg::t_side                      r_side_dly [4];
    logic [sfc_pkg::E_W-1:0]             w_e;

    logic signed [sfc_pkg::TORQUE_W-1:0] w_friction;
    logic signed [sfc_pkg::TORQUE_W-1:0] w_command;
    sfc_pkg::t_dir                       w_dir;
    logic                                w_sat;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= sfc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sfc_pkg::CFG_COULOMB:   r_cfg.coulomb   <= i_cfg_wdata[sfc_pkg::GAIN_W-1:0];
                sfc_pkg::CFG_VISCOUS:   r_cfg.viscous   <= i_cfg_wdata[sfc_pkg::GAIN_W-1:0];
                sfc_pkg::CFG_BREAKAWAY: r_cfg.breakaway <= i_cfg_wdata[sfc_pkg::GAIN_W-1:0];
                sfc_pkg::CFG_INV_SPEED: r_cfg.inv_speed <= i_cfg_wdata[sfc_pkg::GAIN_W-1:0];
                sfc_pkg::CFG_DEADBAND:  r_cfg.deadband  <= i_cfg_wdata[sfc_pkg::DB_W-1:0];
                sfc_pkg::CFG_DAMPING:   r_cfg.damping   <= i_cfg_wdata[sfc_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it loads.
    always_comb begin
        w_rdy[D] = !r_vld[D] || i_m_tready;
        for (int k = D - 1; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_vld[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= D; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = w_rdy[1];
    assign o_m_tvalid = r_vld[D];

    sfc_front u_front (
        .i_clk      (i_clk),
        .i_stage_en (w_rdy[2:1]),
        .i_cfg      (r_cfg),
        .i_speed    (i_s_tdata[23:0]),
        .i_dyn      (i_s_tdata[55:24]),
        .o_x        (w_x),
        .o_side     (w_side)
    );

    sfc_exp #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_exp (
        .i_clk      (i_clk),
        .i_stage_en (w_rdy[6:3]),
        .i_x        (w_x),
        .o_e        (w_e)
    );

    // Side values wait alongside the exponential stages.
    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_side_dly[0] <= w_side;
        end
        for (int i = 1; i < 4; i++) begin
            if (w_rdy[i+3]) begin
                r_side_dly[i] <= r_side_dly[i-1];
            end
        end
    end

    sfc_back u_back (
        .i_clk      (i_clk),
        .i_stage_en (w_rdy[9:7]),
        .i_cfg      (r_cfg),
        .i_side     (r_side_dly[3]),
        .i_e        (w_e),
        .o_friction (w_friction),
        .o_command  (w_command),
        .o_dir      (w_dir),
        .o_sat      (w_sat)
    );

    assign o_m_tdata = {6'b000000, w_dir, w_command, w_friction};
    assign o_m_tuser = w_sat;

endmodule

`default_nettype wire

// ===== rtl/sfc_front.sv =====
// ---------------------------------------------------------------------------
// sfc_front
// Stages one and two: deadband sign, speed magnitude, exponent argument and
// the rounded viscous and damping products.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfc_front (
    input  wire                                   i_clk,
    input  wire  [1:0]                            i_stage_en,
    input  sfc_pkg::t_cfg                         i_cfg,
    input  wire  signed [sfc_pkg::SPEED_W-1:0]    i_speed,
    input  wire  signed [sfc_pkg::TORQUE_W-1:0]   i_dyn,
    output logic [sfc_pkg::X_W-1:0]               o_x,
    output sfc_pkg::t_side                        o_side
);

    localparam int PROD_W = sfc_pkg::SPEED_W + sfc_pkg::GAIN_W;
    localparam logic [PROD_W-1:0] X_LIMIT = PROD_W'(1) << 28;

    logic signed [sfc_pkg::SPEED_W:0]   w_v_ext;
    logic signed [sfc_pkg::SPEED_W:0]   w_th_ext;
    sfc_pkg::t_dir                      w_dir;
    logic [sfc_pkg::SPEED_W-1:0]        w_mag;

    logic [sfc_pkg::SPEED_W-1:0]        r_mag;
    logic                               r_neg;
    sfc_pkg::t_dir                      r_dir;
    logic signed [sfc_pkg::TORQUE_W-1:0] r_dyn;

    logic [PROD_W-1:0]                  w_x_full;
    logic [PROD_W-1:0]                  w_vis_full;
    logic [PROD_W-1:0]                  w_damp_full;
    logic signed [sfc_pkg::GAIN_W:0]    w_stri;
    sfc_pkg::t_side                     n_side;
    logic [sfc_pkg::X_W-1:0]            n_x;

    // Deadband sign with strict comparisons, and the speed magnitude.
    always_comb begin
        w_v_ext  = {i_speed[sfc_pkg::SPEED_W-1], i_speed};
        w_th_ext = {2'b00, i_cfg.deadband};
        if (w_v_ext > w_th_ext) begin
            w_dir = sfc_pkg::DIR_FWD;
        end else if (w_v_ext < -w_th_ext) begin
            w_dir = sfc_pkg::DIR_BWD;
        end else begin
            w_dir = sfc_pkg::DIR_NONE;
        end
        w_mag = i_speed[sfc_pkg::SPEED_W-1] ? (~i_speed + 1'b1) : i_speed;
    end

    always_ff @(posedge i_clk) begin
        if (i_stage_en[0]) begin
            r_mag <= w_mag;
            r_neg <= i_speed[sfc_pkg::SPEED_W-1];
            r_dir <= w_dir;
            r_dyn <= i_dyn;
        end
    end

    // Three products of the magnitude, each rounded or clamped in place.
    always_comb begin
        w_x_full    = PROD_W'(r_mag) * PROD_W'(i_cfg.inv_speed);
        w_vis_full  = PROD_W'(r_mag) * PROD_W'(i_cfg.viscous);
        w_damp_full = PROD_W'(r_mag) * PROD_W'(i_cfg.damping);
        w_stri      = $signed({1'b0, i_cfg.breakaway}) - $signed({1'b0, i_cfg.coulomb});

        n_x = (w_x_full > X_LIMIT) ? sfc_pkg::X_W'(X_LIMIT)
                                   : w_x_full[sfc_pkg::X_W-1:0];

        n_side.neg      = r_neg;
        n_side.dir      = r_dir;
        n_side.dyn      = r_dyn;
        n_side.vis_mag  = sfc_pkg::VIS_W'(((PROD_W+1)'(w_vis_full) + (PROD_W+1)'(32768)) >> 16);
        n_side.damp_mag = sfc_pkg::VIS_W'(((PROD_W+1)'(w_damp_full) + (PROD_W+1)'(32768)) >> 16);
        n_side.stri_neg = w_stri[sfc_pkg::GAIN_W];
        n_side.stri_mag = w_stri[sfc_pkg::GAIN_W] ? sfc_pkg::GAIN_W'(-w_stri)
                                                  : sfc_pkg::GAIN_W'(w_stri);
    end

    always_ff @(posedge i_clk) begin
        if (i_stage_en[1]) begin
            o_x    <= n_x;
            o_side <= n_side;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfc_exp.sv =====
// ---------------------------------------------------------------------------
// sfc_exp
// Four-stage exponential: exp(-x) as the product of an integer-part table,
// two fraction tables and a linear correction for the remaining bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfc_exp #(
    parameter int EXP_TABLE_BITS = sfc_pkg::EXP_TABLE_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire  [3:0]                   i_stage_en,
    input  wire  [sfc_pkg::X_W-1:0]      i_x,
    output logic [sfc_pkg::E_W-1:0]      o_e
);

    localparam int TB      = EXP_TABLE_BITS;
    localparam int TSIZE   = 2 ** TB;
    localparam int FRAC_W  = 25;              // 24 fraction bits and one pad bit
    localparam int RW      = FRAC_W - 2 * TB; // bits left for the linear term
    localparam int Q_W     = 25;              // table values, Q.24 up to 1.0
    localparam int LIN_W   = 26;              // 1 - r in Q.25
    localparam int INT_N   = 32;

    typedef logic [Q_W-1:0] t_tab [TSIZE];
    typedef logic [Q_W-1:0] t_itab [INT_N];

    function automatic t_tab build_frac_tab(input int unsigned shft);
        t_tab tab;
        for (int k = 0; k < TSIZE; k++) begin
            tab[k] = sfc_pkg::exp_neg_q24(k, shft);
        end
        return tab;
    endfunction

    function automatic t_itab build_int_tab();
        t_itab tab;
        for (int n = 0; n < INT_N; n++) begin
            tab[n] = (n <= 16) ? sfc_pkg::exp_neg_q24(n, 0) : '0;
        end
        return tab;
    endfunction

    localparam t_tab  FRAC1_TAB = build_frac_tab(TB);
    localparam t_tab  FRAC2_TAB = build_frac_tab(2 * TB);
    localparam t_itab INT_TAB   = build_int_tab();

    logic [FRAC_W-1:0]     w_frac;
    logic [4:0]            w_int;
    logic [TB-1:0]         w_f1;
    logic [TB-1:0]         w_f2;
    logic [RW-1:0]         w_rem;
    logic [2*Q_W-1:0]      w_p1;
    logic [2*Q_W-1:0]      w_p2;
    logic [Q_W+LIN_W-1:0]  w_p3;
    logic [Q_W:0]          w_round;

    logic [Q_W-1:0]        r_p1;
    logic [TB-1:0]         r_f2;
    logic [LIN_W-1:0]      r_lin3;
    logic [Q_W-1:0]        r_p2;
    logic [LIN_W-1:0]      r_lin4;
    logic [Q_W-1:0]        r_e24;

    // Split the argument into integer part, two table fields and a remainder.
    always_comb begin
        w_frac = {i_x[23:0], 1'b0};
        w_int  = i_x[sfc_pkg::X_W-1:24];
        w_f1   = w_frac[FRAC_W-1 -: TB];
        w_f2   = w_frac[FRAC_W-1-TB -: TB];
        w_rem  = w_frac[RW-1:0];
        w_p1   = (2*Q_W)'(INT_TAB[w_int]) * (2*Q_W)'(FRAC1_TAB[w_f1]);
    end

    // Stage three: integer part times first fraction factor.
    always_ff @(posedge i_clk) begin
        if (i_stage_en[0]) begin
            r_p1   <= w_p1[48:24];
            r_f2   <= w_f2;
            r_lin3 <= (LIN_W'(1) << 25) - LIN_W'(w_rem);
        end
    end

    // Stage four: second fraction factor.
    assign w_p2 = (2*Q_W)'(r_p1) * (2*Q_W)'(FRAC2_TAB[r_f2]);

    always_ff @(posedge i_clk) begin
        if (i_stage_en[1]) begin
            r_p2   <= w_p2[48:24];
            r_lin4 <= r_lin3;
        end
    end

    // Stage five: linear correction for the low bits, exp(-r) ~ 1 - r.
    assign w_p3 = (Q_W+LIN_W)'(r_p2) * (Q_W+LIN_W)'(r_lin4);

    always_ff @(posedge i_clk) begin
        if (i_stage_en[2]) begin
            r_e24 <= w_p3[49:25];
        end
    end

    // Stage six: round to Q0.16 and cap below 1.0.
    assign w_round = ((Q_W+1)'(r_e24) + (Q_W+1)'(128)) >> 8;

    always_ff @(posedge i_clk) begin
        if (i_stage_en[3]) begin
            o_e <= (w_round > (Q_W+1)'(16'hFFFF)) ? 16'hFFFF : w_round[sfc_pkg::E_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfc_back.sv =====
// ---------------------------------------------------------------------------
// sfc_back
// Stages seven to nine: Stribeck term, friction and command sums, saturation
// and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfc_back (
    input  wire                                   i_clk,
    input  wire  [2:0]                            i_stage_en,
    input  sfc_pkg::t_cfg                         i_cfg,
    input  sfc_pkg::t_side                        i_side,
    input  wire  [sfc_pkg::E_W-1:0]               i_e,
    output logic signed [sfc_pkg::TORQUE_W-1:0]   o_friction,
    output logic signed [sfc_pkg::TORQUE_W-1:0]   o_command,
    output sfc_pkg::t_dir                         o_dir,
    output logic                                  o_sat
);

    localparam int SP_W = sfc_pkg::GAIN_W + sfc_pkg::E_W;
    localparam int FW   = sfc_pkg::FRIC_W;
    localparam int CW   = sfc_pkg::CMD_W;

    logic [SP_W-1:0]                 w_sprod;
    sfc_pkg::t_side                  r7_side;
    logic [sfc_pkg::STRI_W-1:0]      r7_stri;

    logic signed [FW-1:0]            w_coul;
    logic signed [FW-1:0]            w_vis;
    logic signed [FW-1:0]            w_stri_s;
    logic signed [FW-1:0]            w_stri_d;
    logic signed [CW-1:0]            w_damp;
    logic signed [CW-1:0]            w_dyn;
    logic signed [FW-1:0]            r8_fric;
    logic signed [CW-1:0]            r8_cpart;
    sfc_pkg::t_dir                   r8_dir;

    logic signed [CW-1:0]            w_fric_ext;
    logic signed [CW-1:0]            w_cmd;
    sfc_pkg::t_sat                   w_fsat;
    sfc_pkg::t_sat                   w_csat;

    // Stage seven: (Fs - Fc) magnitude times the exponential, rounded to Q.8.
    assign w_sprod = SP_W'(i_side.stri_mag) * SP_W'(i_e);

    always_ff @(posedge i_clk) begin
        if (i_stage_en[0]) begin
            r7_side <= i_side;
            r7_stri <= sfc_pkg::STRI_W'(((SP_W+1)'(w_sprod) + (SP_W+1)'(32768)) >> 16);
        end
    end

    // Stage eight: signed terms, friction sum and dynamics minus damping.
    always_comb begin
        w_vis    = r7_side.neg ? -$signed(FW'(r7_side.vis_mag)) : $signed(FW'(r7_side.vis_mag));
        w_stri_s = r7_side.stri_neg ? -$signed(FW'(r7_stri)) : $signed(FW'(r7_stri));
        unique case (r7_side.dir)
            sfc_pkg::DIR_FWD: begin
                w_coul   = $signed(FW'(i_cfg.coulomb));
                w_stri_d = w_stri_s;
            end
            sfc_pkg::DIR_BWD: begin
                w_coul   = -$signed(FW'(i_cfg.coulomb));
                w_stri_d = -w_stri_s;
            end
            default: begin
                w_coul   = '0;
                w_stri_d = '0;
            end
        endcase
        w_damp = r7_side.neg ? -$signed(CW'(r7_side.damp_mag))
                             : $signed(CW'(r7_side.damp_mag));
        w_dyn  = {{(CW-sfc_pkg::TORQUE_W){r7_side.dyn[sfc_pkg::TORQUE_W-1]}}, r7_side.dyn};
    end

    always_ff @(posedge i_clk) begin
        if (i_stage_en[1]) begin
            r8_fric  <= w_coul + w_vis + w_stri_d;
            r8_cpart <= w_dyn - w_damp;
            r8_dir   <= r7_side.dir;
        end
    end

    // Stage nine: command from the unsaturated friction, then clip both.
    always_comb begin
        w_fric_ext = {{(CW-FW){r8_fric[FW-1]}}, r8_fric};
        w_cmd      = r8_cpart + w_fric_ext;
        w_fsat     = sfc_pkg::sat32(w_fric_ext);
        w_csat     = sfc_pkg::sat32(w_cmd);
    end

    always_ff @(posedge i_clk) begin
        if (i_stage_en[2]) begin
            o_friction <= w_fsat.val;
            o_command  <= w_csat.val;
            o_dir      <= r8_dir;
            o_sat      <= w_fsat.clip | w_csat.clip;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfc_checker.sv =====
// ---------------------------------------------------------------------------
// sfc_checker
// Port-level checks on the friction compensation block, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfc_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_s_tready,
    input wire [sfc_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input wire [sfc_pkg::OUT_TUSER_W-1:0]   o_m_tuser,
    input wire                              o_m_tvalid,
    input wire                              i_m_tready
);

    // A stalled result item keeps its value.
    `SFC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")

    // With the output register empty the whole pipe can move, so input is taken.
    `SFC_ASSERT_IMP(a_empty_ready, i_clk, i_rst_n, !o_m_tvalid, o_s_tready, "input refused while output empty")

    // The direction field never carries the unused code.
    `SFC_ASSERT_IMP(a_dir_code, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[65:64] != 2'b10, "bad direction code")

    // A clip flag means one of the torques sits at a rail.
    `SFC_ASSERT_IMP(a_sat_rail, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata[31:0] == 32'h7FFF_FFFF || o_m_tdata[31:0] == 32'h8000_0000 || o_m_tdata[63:32] == 32'h7FFF_FFFF || o_m_tdata[63:32] == 32'h8000_0000, "clip flag without a rail value")

endmodule

bind stribeck_friction_compensation sfc_checker u_sfc_checker (.*);

`default_nettype wire

// ===== dv/tb_stribeck_friction_compensation.sv =====
// ---------------------------------------------------------------------------
// tb_stribeck_friction_compensation
// Streams joint speed and dynamics torque items through the friction block
// under several register settings, predicts every result and compares each
// output item field by field, with random gaps on input and output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stribeck_friction_compensation;

    import sfc_pkg::*;

    localparam int IDLE_PCT     = 19;
    // Longest run of cycles with no item moving on either side; register
    // loads and random stalls stay far below this in a healthy run.
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASES       = 8;
    localparam longint SPEED_MAX = 64'sd8388607;
    localparam longint SPEED_MIN = -64'sd8388608;

    // Indexes that decode to no register; writes to them must be ignored.
    localparam t_cfg_idx CFG_UNUSED_LO = 3'd6;
    localparam t_cfg_idx CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic signed [TORQUE_W-1:0] friction;
        logic signed [TORQUE_W-1:0] command;
        t_dir                       direction;
        logic                       saturated;
    } torque_set_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0]  speed;
        logic signed [TORQUE_W-1:0] dyn;
        t_cfg                       regs;
        longint                     weight;
        torque_set_t                want;
    } torque_entry_t;

    // Scoreboard: register copy, friction prediction and result check.
    class friction_scoreboard;
        t_cfg          regs;
        torque_entry_t expected_torques[$];
        int unsigned   checked;
        int unsigned   clipped;
        int unsigned   mismatches;

        function new();
            regs       = CFG_RESET;
            checked    = 0;
            clipped    = 0;
            mismatches = 0;
        endfunction

        function void apply_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_COULOMB:   regs.coulomb   = val[GAIN_W-1:0];
                CFG_VISCOUS:   regs.viscous   = val[GAIN_W-1:0];
                CFG_BREAKAWAY: regs.breakaway = val[GAIN_W-1:0];
                CFG_INV_SPEED: regs.inv_speed = val[GAIN_W-1:0];
                CFG_DEADBAND:  regs.deadband  = val[DB_W-1:0];
                CFG_DAMPING:   regs.damping   = val[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // round(65536 * exp(-|v| * inverse speed)), argument clamped at 16.
        function longint stribeck_weight(logic signed [SPEED_W-1:0] speed,
                                         logic [GAIN_W-1:0] inv);
            longint v;
            longint x;
            real    w;
            int     q;
            v = speed;
            if (v < 0) v = -v;
            x = v * inv;
            if (x > (64'sd16 <<< 24)) x = 64'sd16 <<< 24;
            w = 65536.0 * $exp(-$itor(x) / 16777216.0);
            q = $rtoi(w + 0.5);
            if (q > 65535) q = 65535;
            return q;
        endfunction

        // Q.24 magnitude to signed Q.8, half away from zero.
        function longint round_q8(longint mag, bit neg);
            longint q;
            q = (mag + 32768) >>> 16;
            return neg ? -q : q;
        endfunction

        function longint clamp32(longint a, inout bit clip);
            if (a > 64'sd2147483647) begin
                clip = 1'b1;
                return 64'sd2147483647;
            end
            if (a < -64'sd2147483648) begin
                clip = 1'b1;
                return -64'sd2147483648;
            end
            return a;
        endfunction

        function torque_set_t torques_for(logic signed [SPEED_W-1:0] speed,
                                          logic signed [TORQUE_W-1:0] dyn,
                                          t_cfg c, longint weight);
            torque_set_t r;
            longint      v;
            longint      mag;
            longint      th;
            longint      d;
            longint      fc;
            longint      slip;
            longint      stri;
            longint      fric;
            longint      cmd;
            longint      dyn_w;
            bit          neg;
            bit          clip;
            v     = speed;
            dyn_w = dyn;
            th    = c.deadband;
            fc    = c.coulomb;
            slip  = c.breakaway;
            slip  = slip - fc;
            neg   = (v < 0);
            mag   = neg ? -v : v;
            // Strict comparison against the deadband on both sides.
            if (v > th) d = 1;
            else if (v < -th) d = -1;
            else d = 0;
            // With Coulomb above breakaway the Stribeck term turns negative.
            stri = round_q8((slip < 0 ? -slip : slip) * weight, slip < 0) * d;
            fric = fc * d + round_q8(mag * c.viscous, neg) + stri;
            cmd  = dyn_w + fric - round_q8(mag * c.damping, neg);
            clip = 1'b0;
            r.friction  = clamp32(fric, clip);
            r.command   = clamp32(cmd, clip);
            r.saturated = clip;
            r.direction = (d > 0) ? DIR_FWD : (d < 0) ? DIR_BWD : DIR_NONE;
            return r;
        endfunction

        function void note_input(logic signed [SPEED_W-1:0] speed,
                                 logic signed [TORQUE_W-1:0] dyn);
            torque_entry_t ent;
            ent.speed  = speed;
            ent.dyn    = dyn;
            ent.regs   = regs;
            ent.weight = stribeck_weight(speed, regs.inv_speed);
            ent.want   = torques_for(speed, dyn, regs, ent.weight);
            expected_torques.push_back(ent);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata,
                                   logic [OUT_TUSER_W-1:0] tuser);
            torque_entry_t ent;
            torque_set_t   got;
            longint        e;
            bit            ok;
            got.friction  = tdata[31:0];
            got.command   = tdata[63:32];
            got.direction = tdata[65:64];
            got.saturated = tuser[0];
            if (expected_torques.size() == 0) begin
                $error("output item with none expected: tdata=%h tuser=%b", tdata, tuser);
                mismatches++;
                return;
            end
            ent = expected_torques.pop_front();
            checked++;
            if (got.saturated === 1'b1) clipped++;
            // The exponential may be off by up to two LSB in hardware.
            ok = (got === ent.want);
            for (e = ent.weight - 2; e <= ent.weight + 2 && !ok; e++) begin
                if (e >= 0 && e <= 65535)
                    ok = (got === torques_for(ent.speed, ent.dyn, ent.regs, e));
            end
            if (!ok) begin
                mismatches++;
                if (got.friction !== ent.want.friction)
                    $error("friction_torque: expected %0d, got %0d",
                           ent.want.friction, got.friction);
                if (got.command !== ent.want.command)
                    $error("command_torque: expected %0d, got %0d",
                           ent.want.command, got.command);
                if (got.direction !== ent.want.direction)
                    $error("motion_direction: expected %b, got %b",
                           ent.want.direction, got.direction);
                if (got.saturated !== ent.want.saturated)
                    $error("saturated: expected %b, got %b",
                           ent.want.saturated, got.saturated);
            end
        endfunction
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic [IN_TDATA_W-1:0]   i_s_tdata   = '0;
    logic                    i_s_tvalid  = 1'b0;
    logic                    o_s_tready;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    logic [OUT_TUSER_W-1:0]  o_m_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready  = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;

    friction_scoreboard board = new();
    bit                 steady = 1'b0;
    int unsigned        items_sent = 0;
    int unsigned        stall_cycles = 0;

    stribeck_friction_compensation uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Output back-pressure, switched off during the steady phase.
    always @(negedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Every accepted output item is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result(o_m_tdata, o_m_tuser);
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_stribeck_friction_compensation failed");
            $finish;
        end
    end

    // Present one item, with random gaps ahead of it, and wait for acceptance.
    task automatic send_item(input logic signed [SPEED_W-1:0] spd,
                             input logic signed [TORQUE_W-1:0] dyn);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tdata  <= {dyn, spd};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_input(spd, dyn);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        board.apply_write(idx, val);
    endtask

    task automatic wait_drain();
        while (board.expected_torques.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_cfg                       setting;
        longint                     v;
        longint                     th;
        logic signed [TORQUE_W-1:0] dyn;
        int                         ph;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items at the reset settings: deadband edges, rounding
        // ties, the exponential clamp, full-scale speeds and saturation.
        send_item(24'sd0, 32'sd0);
        send_item(24'sd131, 32'sd0);
        send_item(-24'sd131, 32'sd0);
        send_item(24'sd132, 32'sd0);
        send_item(-24'sd132, 32'sd0);
        send_item(24'sd64, 32'sd1000);
        send_item(-24'sd64, -32'sd1000);
        send_item(24'sd128, 32'sd0);
        send_item(-24'sd128, 32'sd0);
        send_item(24'sd1, 32'sd0);
        send_item(-24'sd1, 32'sd0);
        send_item(24'sd104857, 32'sd0);
        send_item(24'sd104858, 32'sd0);
        send_item(-24'sd200000, 32'sd0);
        send_item(24'sd8388607, 32'sd0);
        send_item(-24'sd8388608, 32'sd0);
        send_item(24'sd0, 32'sh7FFF_FFFF);
        send_item(24'sd0, 32'sh8000_0000);
        send_item(24'sd8388607, 32'sh7FFF_FFFF);
        send_item(-24'sd8388608, 32'sh8000_0000);
        send_item(24'sd8388607, 32'sh8000_0000);
        send_item(-24'sd8388608, 32'sh7FFF_FFFF);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: setting = CFG_RESET;
                1: begin
                    setting = '1;
                    setting.deadband = '0;
                end
                2: setting = '1;
                3: setting = '0;
                4: begin
                    // Coulomb level above breakaway.
                    setting           = CFG_RESET;
                    setting.coulomb   = 20'd20480;
                    setting.breakaway = 20'd5120;
                    setting.inv_speed = 20'd640;
                    setting.deadband  = 23'd500;
                    setting.damping   = 20'd2000;
                end
                5: begin
                    setting.coulomb   = 20'($urandom);
                    setting.viscous   = 20'($urandom);
                    setting.breakaway = 20'($urandom);
                    setting.inv_speed = 20'($urandom);
                    setting.deadband  = 23'($urandom);
                    setting.damping   = 20'($urandom);
                end
                default: begin
                    setting.coulomb   = 20'($urandom_range(65535));
                    setting.viscous   = 20'($urandom_range(65535));
                    setting.breakaway = 20'($urandom_range(65535));
                    setting.inv_speed = 20'($urandom_range(3000));
                    setting.deadband  = 23'($urandom_range(20000));
                    setting.damping   = 20'($urandom_range(4095));
                end
            endcase

            // Registers change only with the pipeline empty.
            i_s_tvalid <= 1'b0;
            wait_drain();
            write_register(CFG_UNUSED_LO, 23'($urandom));
            write_register(CFG_COULOMB, {3'($urandom), setting.coulomb});
            write_register(CFG_VISCOUS, {3'($urandom), setting.viscous});
            write_register(CFG_BREAKAWAY, {3'($urandom), setting.breakaway});
            write_register(CFG_INV_SPEED, {3'($urandom), setting.inv_speed});
            write_register(CFG_DEADBAND, setting.deadband);
            write_register(CFG_DAMPING, {3'($urandom), setting.damping});
            write_register(CFG_UNUSED_HI, 23'($urandom));
            i_cfg_we <= 1'b0;
            @(negedge i_clk);

            steady = (ph == 0);
            th = setting.deadband;
            repeat (PHASE_ITEMS) begin
                case ($urandom_range(9))
                    0, 1, 2: begin
                        v = th + longint'($urandom_range(8)) - 4;
                        if ($urandom_range(1)) v = -v;
                    end
                    3, 4: begin
                        v = longint'($urandom_range(4095));
                        if ($urandom_range(1)) v = -v;
                    end
                    5, 6: v = longint'($urandom_range(16777215)) - 8388608;
                    7: begin
                        case ($urandom_range(3))
                            0: v = SPEED_MAX;
                            1: v = SPEED_MIN;
                            2: v = 0;
                            default: v = $urandom_range(1) ? 1 : -1;
                        endcase
                    end
                    default: begin
                        v = longint'($urandom_range(262143));
                        if ($urandom_range(1)) v = -v;
                    end
                endcase
                if (v > SPEED_MAX) v = SPEED_MAX;
                if (v < SPEED_MIN) v = SPEED_MIN;

                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: dyn = $urandom;
                    6: dyn = 32'sh7FFF_FFFF - $urandom_range(1 << 20);
                    7: dyn = 32'sh8000_0000 + $urandom_range(1 << 20);
                    default: dyn = $urandom_range(131071) - 65536;
                endcase
                send_item(v[SPEED_W-1:0], dyn);
            end
            steady = 1'b0;
        end

        i_s_tvalid <= 1'b0;
        wait_drain();
        repeat (PIPE_DEPTH + 4) @(negedge i_clk);

        $display("Sent %0d items through %0d register settings plus a directed set;",
                 items_sent, PHASES);
        $display("checked %0d output items, %0d of them saturated.",
                 board.checked, board.clipped);
        if (board.mismatches == 0 && board.expected_torques.size() == 0) begin
            $display("tb_stribeck_friction_compensation passed");
        end else begin
            $display("tb_stribeck_friction_compensation failed");
        end
        $finish;
    end

endmodule
